// File: rtl/lcf_pkg.sv
// Package for the LX200 command framer: codes, constants, types and the family lookup.
package lcf_pkg;

   localparam int MAX_COMMAND_LEN_DEFAULT = 64;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_PREFIX     = 1'b0;
   localparam logic [0:0] REG_TERMINATOR = 1'b1;

   localparam logic [7:0] PREFIX_RESET     = 8'd58;
   localparam logic [7:0] TERMINATOR_RESET = 8'd35;

   localparam logic [2:0] STATUS_INCOMPLETE = 3'd0;
   localparam logic [2:0] STATUS_OK         = 3'd1;
   localparam logic [2:0] STATUS_BAD_PREFIX = 3'd2;
   localparam logic [2:0] STATUS_TOO_SHORT  = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW   = 3'd4;

   localparam logic [2:0] ROLE_PREFIX  = 3'd0;
   localparam logic [2:0] ROLE_COMMAND = 3'd1;
   localparam logic [2:0] ROLE_PARAM   = 3'd2;
   localparam logic [2:0] ROLE_TERM    = 3'd3;
   localparam logic [2:0] ROLE_DISCARD = 3'd4;

   localparam logic [1:0] CMD_MAX = 2'd3;

   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UZ    = 8'h5A;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LZ    = 8'h7A;

   typedef struct packed {
      logic [7:0] prefix_char;
      logic [7:0] terminator_char;
   } cfg_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] byte_role;
      logic [7:0] echo_byte;
      logic [7:0] cmd_first;
      logic [7:0] cmd_second;
      logic [7:0] cmd_third;
      logic [1:0] cmd_length;
      logic [4:0] family;
      logic       has_param;
      logic [5:0] param_length;
   } result_type;

   function automatic logic [4:0] family_of(input logic [7:0] c);
      logic [4:0] f;
      case (c)
         8'h41:   f = 5'd1;
         8'h42:   f = 5'd2;
         8'h43:   f = 5'd3;
         8'h44:   f = 5'd4;
         8'h46:   f = 5'd5;
         8'h47:   f = 5'd6;
         8'h67:   f = 5'd7;
         8'h48:   f = 5'd8;
         8'h49:   f = 5'd9;
         8'h4C:   f = 5'd10;
         8'h4D:   f = 5'd11;
         8'h50:   f = 5'd12;
         8'h51:   f = 5'd13;
         8'h52:   f = 5'd14;
         8'h53:   f = 5'd15;
         8'h54:   f = 5'd16;
         8'h55:   f = 5'd17;
         default: f = 5'd0;
      endcase
      return f;
   endfunction

endpackage

// File: rtl/lcf_req_if.sv
// Input byte channel of the command framer.
interface lcf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// File: rtl/lcf_rsp_if.sv
// Result channel of the command framer.
interface lcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [2:0] byte_role;
   logic [7:0] echo_byte;
   logic [7:0] cmd_first;
   logic [7:0] cmd_second;
   logic [7:0] cmd_third;
   logic [1:0] cmd_length;
   logic [4:0] family;
   logic       has_param;
   logic [5:0] param_length;

   modport source (output valid, output status, output byte_role, output echo_byte,
                   output cmd_first, output cmd_second, output cmd_third,
                   output cmd_length, output family, output has_param,
                   output param_length, input ready);
   modport sink   (input valid, input status, input byte_role, input echo_byte,
                   input cmd_first, input cmd_second, input cmd_third,
                   input cmd_length, input family, input has_param,
                   input param_length, output ready);
endinterface

// File: rtl/lcf_csr.sv
// APB-style register block holding the prefix and terminator bytes.
module lcf_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [lcf_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [lcf_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [lcf_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready,
   output lcf_pkg::cfg_type                      cfg
);

   lcf_pkg::cfg_type cfg_ff;
   lcf_pkg::cfg_type cfg_in;
   logic [0:0]       index;
   logic             wr_en;

   assign index      = csr_paddr[2:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            lcf_pkg::REG_PREFIX:     cfg_in.prefix_char     = csr_pwdata[7:0];
            lcf_pkg::REG_TERMINATOR: cfg_in.terminator_char = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         lcf_pkg::REG_PREFIX:     csr_prdata = {24'd0, cfg_ff.prefix_char};
         lcf_pkg::REG_TERMINATOR: csr_prdata = {24'd0, cfg_ff.terminator_char};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prefix_char     <= lcf_pkg::PREFIX_RESET;
         cfg_ff.terminator_char <= lcf_pkg::TERMINATOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/lcf_core.sv
// Frame state and per-byte classification of the command framer.
module lcf_core #(
   parameter int MAX_COMMAND_LEN = lcf_pkg::MAX_COMMAND_LEN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           data_byte,
   input  lcf_pkg::cfg_type     cfg,
   output lcf_pkg::result_type  result
);

   localparam int CNT_W = $clog2(MAX_COMMAND_LEN);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_COMMAND_LEN - 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic             prefix_bad_ff, prefix_bad_in;
   logic [7:0]       cmd_chars_ff [3];
   logic [7:0]       cmd_chars_in [3];
   logic [1:0]       cmd_count_ff, cmd_count_in;
   logic             in_param_ff, in_param_in;
   logic [CNT_W-1:0] param_count_ff, param_count_in;

   logic overflow, is_term, is_first, is_letter, lead_sign, lead_digit, takes;

   assign overflow  = byte_count_ff >= CNT_LAST;
   assign is_term   = data_byte == cfg.terminator_char;
   assign is_first  = byte_count_ff == '0;
   assign is_letter = (data_byte >= lcf_pkg::CHAR_UA && data_byte <= lcf_pkg::CHAR_UZ) ||
                      (data_byte >= lcf_pkg::CHAR_LA && data_byte <= lcf_pkg::CHAR_LZ);
   assign lead_sign = (cmd_chars_ff[0] == lcf_pkg::CHAR_B || cmd_chars_ff[0] == lcf_pkg::CHAR_F ||
                       cmd_chars_ff[0] == lcf_pkg::CHAR_T) &&
                      (data_byte == lcf_pkg::CHAR_PLUS || data_byte == lcf_pkg::CHAR_MINUS);
   assign lead_digit = cmd_chars_ff[0] == lcf_pkg::CHAR_R &&
                       data_byte >= lcf_pkg::CHAR_0 && data_byte <= lcf_pkg::CHAR_9;
   assign takes = (cmd_count_ff != lcf_pkg::CMD_MAX) &&
                  (is_letter || (cmd_count_ff != 2'd0 && (lead_sign || lead_digit)));

   always_comb begin
      byte_count_in  = byte_count_ff;
      prefix_bad_in  = prefix_bad_ff;
      cmd_chars_in   = cmd_chars_ff;
      cmd_count_in   = cmd_count_ff;
      in_param_in    = in_param_ff;
      param_count_in = param_count_ff;

      result           = '0;
      result.echo_byte = data_byte;
      result.status    = lcf_pkg::STATUS_INCOMPLETE;

      if (overflow) begin
         result.status    = lcf_pkg::STATUS_OVERFLOW;
         result.byte_role = lcf_pkg::ROLE_DISCARD;
      end else if (is_term) begin
         result.byte_role = lcf_pkg::ROLE_TERM;
         if (is_first) begin
            result.status = lcf_pkg::STATUS_TOO_SHORT;
         end else if (prefix_bad_ff) begin
            result.status = lcf_pkg::STATUS_BAD_PREFIX;
         end else begin
            result.status       = lcf_pkg::STATUS_OK;
            result.cmd_first    = cmd_chars_ff[0];
            result.cmd_second   = cmd_chars_ff[1];
            result.cmd_third    = cmd_chars_ff[2];
            result.cmd_length   = cmd_count_ff;
            result.family       = (cmd_count_ff != 2'd0) ?
                                  lcf_pkg::family_of(cmd_chars_ff[0]) : 5'd0;
            result.has_param    = param_count_ff != '0;
            result.param_length = 6'(param_count_ff);
         end
      end else if (is_first) begin
         result.byte_role = (data_byte == cfg.prefix_char) ?
                            lcf_pkg::ROLE_PREFIX : lcf_pkg::ROLE_DISCARD;
      end else if (prefix_bad_ff) begin
         result.byte_role = lcf_pkg::ROLE_DISCARD;
      end else if (!in_param_ff && takes) begin
         result.byte_role = lcf_pkg::ROLE_COMMAND;
      end else begin
         result.byte_role = lcf_pkg::ROLE_PARAM;
      end

      if (fire) begin
         if (overflow || is_term) begin
            byte_count_in  = '0;
            prefix_bad_in  = 1'b0;
            cmd_chars_in   = '{default: 8'd0};
            cmd_count_in   = 2'd0;
            in_param_in    = 1'b0;
            param_count_in = '0;
         end else begin
            byte_count_in = byte_count_ff + CNT_ONE;
            if (is_first) begin
               prefix_bad_in = data_byte != cfg.prefix_char;
            end else if (prefix_bad_ff) begin
               prefix_bad_in = 1'b1;
            end else if (!in_param_ff && takes) begin
               for (int i = 0; i < 3; i++) begin
                  if (cmd_count_ff == 2'(i)) cmd_chars_in[i] = data_byte;
               end
               cmd_count_in = cmd_count_ff + 2'd1;
            end else begin
               in_param_in    = 1'b1;
               param_count_in = param_count_ff + CNT_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         prefix_bad_ff  <= 1'b0;
         cmd_chars_ff   <= '{default: 8'd0};
         cmd_count_ff   <= 2'd0;
         in_param_ff    <= 1'b0;
         param_count_ff <= '0;
      end else begin
         byte_count_ff  <= byte_count_in;
         prefix_bad_ff  <= prefix_bad_in;
         cmd_chars_ff   <= cmd_chars_in;
         cmd_count_ff   <= cmd_count_in;
         in_param_ff    <= in_param_in;
         param_count_ff <= param_count_in;
      end
   end

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      fire && !overflow && is_term |=> byte_count_ff == '0 && cmd_count_ff == 2'd0)
      else $error("frame not cleared after terminator");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CNT_LAST)
      else $error("byte count past limit");

   a_lead_char: assert property (@(posedge clock) disable iff (reset)
      cmd_count_ff != 2'd0 |-> cmd_chars_ff[0] != 8'd0)
      else $error("command count without first char");

   a_param_flag: assert property (@(posedge clock) disable iff (reset)
      in_param_ff == (param_count_ff != '0))
      else $error("parameter flag and count disagree");

endmodule

// File: rtl/lcf_out_buf.sv
// Result register with skid stage between the core and the result channel.
module lcf_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lcf_pkg::result_type push_data,
   output logic                push_ready,
   lcf_rsp_if.source           rsp_chan
);

   lcf_pkg::result_type main_ff, main_in, skid_ff, skid_in;
   logic                main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   logic                pop;

   assign push_ready = !skid_valid_ff;
   assign pop        = main_valid_ff && rsp_chan.ready;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_chan.valid        = main_valid_ff;
   assign rsp_chan.status       = main_ff.status;
   assign rsp_chan.byte_role    = main_ff.byte_role;
   assign rsp_chan.echo_byte    = main_ff.echo_byte;
   assign rsp_chan.cmd_first    = main_ff.cmd_first;
   assign rsp_chan.cmd_second   = main_ff.cmd_second;
   assign rsp_chan.cmd_third    = main_ff.cmd_third;
   assign rsp_chan.cmd_length   = main_ff.cmd_length;
   assign rsp_chan.family       = main_ff.family;
   assign rsp_chan.has_param    = main_ff.has_param;
   assign rsp_chan.param_length = main_ff.param_length;

endmodule

// File: rtl/lx200_command_framer_top.sv
// Top level of the LX200 command framer.
//
//   channel   dir   handshake              payload
//   req_chan  in    valid/ready            data_byte
//   rsp_chan  out   valid/ready            status .. param_length
//   csr_*     in    psel/penable/pwrite    prefix_char @0x0, terminator_char @0x4
//
// One byte per cycle while req_chan.ready is high: each transfer is classified in
// the cycle it is taken and its result is registered for rsp_chan.
// Synchronous reset clears the frame state and restores ':' and '#'.
// A stalled rsp_chan fills the result register, then the skid stage; req_chan.ready
// drops only while the skid stage holds a result.
module lx200_command_framer_top #(
   parameter int MAX_COMMAND_LEN = lcf_pkg::MAX_COMMAND_LEN_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lcf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lcf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lcf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   lcf_req_if.sink                        req_chan,
   lcf_rsp_if.source                      rsp_chan
);

   lcf_pkg::cfg_type    cfg;
   lcf_pkg::result_type result;
   logic                push_ready;
   logic                fire;

   assign req_chan.ready = push_ready;
   assign fire           = req_chan.valid && push_ready;

   lcf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lcf_core #(
      .MAX_COMMAND_LEN (MAX_COMMAND_LEN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (req_chan.data_byte),
      .cfg       (cfg),
      .result    (result)
   );

   lcf_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .push_data  (result),
      .push_ready (push_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: tb/tb_lx200_command_framer_top.sv
// Self-checking testbench for the LX200 command framer: byte stream stimulus, CSR writes, result checks.
`timescale 1ns / 1ps

module tb_lx200_command_framer_top;
   import lcf_pkg::*;

   localparam int    FRAME_LIMIT    = MAX_COMMAND_LEN_DEFAULT;
   localparam string FAMILY_LETTERS = "ABCDFGgHILMPQRSTU";

   // Tracks the frame state of the framer and holds the results it should produce.
   class frame_tracker;
      logic [7:0] prefix_char;
      logic [7:0] term_char;
      logic [7:0] cmd [3];
      int         kept;
      int         cmd_count;
      int         param_count;
      bit         bad;
      bit         in_param;
      result_type expected_results [$];
      int         mismatches;

      function new();
         prefix_char = PREFIX_RESET;
         term_char   = TERMINATOR_RESET;
         mismatches  = 0;
         clear();
      endfunction

      function void clear();
         kept        = 0;
         cmd_count   = 0;
         param_count = 0;
         bad         = 0;
         in_param    = 0;
         cmd[0]      = 8'h00;
         cmd[1]      = 8'h00;
         cmd[2]      = 8'h00;
      endfunction

      function void set_register(logic [0:0] idx, logic [7:0] value);
         if (idx == REG_PREFIX) begin
            prefix_char = value;
         end else begin
            term_char = value;
         end
      endfunction

      function bit is_letter(logic [7:0] c);
         return (c >= CHAR_UA && c <= CHAR_UZ) || (c >= CHAR_LA && c <= CHAR_LZ);
      endfunction

      function bit accepts_command(logic [7:0] c);
         if (cmd_count >= 3) return 0;
         if (is_letter(c)) return 1;
         if (cmd_count == 0) return 0;
         if ((cmd[0] == CHAR_B || cmd[0] == CHAR_F || cmd[0] == CHAR_T) &&
             (c == CHAR_PLUS || c == CHAR_MINUS)) return 1;
         return cmd[0] == CHAR_R && c >= CHAR_0 && c <= CHAR_9;
      endfunction

      function logic [4:0] family_code(logic [7:0] c);
         for (int i = 0; i < FAMILY_LETTERS.len(); i++) begin
            if (FAMILY_LETTERS[i] == c) return 5'(i + 1);
         end
         return 5'd0;
      endfunction

      function void take_byte(logic [7:0] b);
         result_type r;
         r = '0;
         r.echo_byte = b;
         if (kept >= FRAME_LIMIT - 1) begin
            r.status    = STATUS_OVERFLOW;
            r.byte_role = ROLE_DISCARD;
            clear();
         end else if (b == term_char) begin
            r.byte_role = ROLE_TERM;
            if (kept == 0) begin
               r.status = STATUS_TOO_SHORT;
            end else if (bad) begin
               r.status = STATUS_BAD_PREFIX;
            end else begin
               r.status       = STATUS_OK;
               r.cmd_first    = cmd[0];
               r.cmd_second   = cmd[1];
               r.cmd_third    = cmd[2];
               r.cmd_length   = 2'(cmd_count);
               r.family       = (cmd_count > 0) ? family_code(cmd[0]) : 5'd0;
               r.has_param    = param_count > 0;
               r.param_length = 6'(param_count);
            end
            clear();
         end else if (kept == 0) begin
            if (b == prefix_char) begin
               r.byte_role = ROLE_PREFIX;
            end else begin
               bad         = 1;
               r.byte_role = ROLE_DISCARD;
            end
            kept++;
         end else if (bad) begin
            r.byte_role = ROLE_DISCARD;
            kept++;
         end else if (!in_param && accepts_command(b)) begin
            cmd[cmd_count] = b;
            cmd_count++;
            r.byte_role = ROLE_COMMAND;
            kept++;
         end else begin
            in_param = 1;
            param_count++;
            r.byte_role = ROLE_PARAM;
            kept++;
         end
         expected_results.push_back(r);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got echo_byte %0d",
                     $time, got.echo_byte);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("status", 8'(want.status), 8'(got.status));
         compare_field("byte_role", 8'(want.byte_role), 8'(got.byte_role));
         compare_field("echo_byte", want.echo_byte, got.echo_byte);
         compare_field("cmd_first", want.cmd_first, got.cmd_first);
         compare_field("cmd_second", want.cmd_second, got.cmd_second);
         compare_field("cmd_third", want.cmd_third, got.cmd_third);
         compare_field("cmd_length", 8'(want.cmd_length), 8'(got.cmd_length));
         compare_field("family", 8'(want.family), 8'(got.family));
         compare_field("has_param", 8'(want.has_param), 8'(got.has_param));
         compare_field("param_length", 8'(want.param_length), 8'(got.param_length));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lcf_req_if req_bus ();
   lcf_rsp_if rsp_bus ();

   frame_tracker tracker = new();
   int bytes_sent   = 0;
   int results_seen = 0;
   int burst_left   = 0;

   lx200_command_framer_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [7:0] any_letter();
      logic [7:0] offset;
      offset = 8'($urandom_range(0, 25));
      return ($urandom_range(0, 1) != 0) ? CHAR_UA + offset : CHAR_LA + offset;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      int pick;
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 5) burst_left = $urandom_range(20, 60);
         else if (pick < 22) gap = $urandom_range(1, 3);
         else if (pick < 26) gap = $urandom_range(5, 20);
      end
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.data_byte = b;
      do @(posedge clock); while (!req_bus.ready);
      tracker.take_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Framed byte run with random content (it may run past the frame limit), or line noise. A forced
   // parameter count sends no command part, only that many random bytes before the terminator.
   task automatic send_random_frame(input int forced_params);
      logic [7:0] bytes_out [$];
      logic [7:0] lead;
      logic [7:0] c;
      int         ncmd;
      int         nparam;
      int         pick;
      pick = $urandom_range(0, 99);
      if (forced_params >= 0 || pick < 75) begin
         bytes_out.push_back(tracker.prefix_char);
         ncmd = (forced_params >= 0) ? 0 : $urandom_range(0, 3);
         lead = ($urandom_range(0, 1) != 0) ? FAMILY_LETTERS[$urandom_range(0, 16)]
                                            : any_letter();
         for (int k = 0; k < ncmd; k++) begin
            c = any_letter();
            if (k == 0) begin
               c = lead;
            end else if ((lead == CHAR_B || lead == CHAR_F || lead == CHAR_T) &&
                         $urandom_range(0, 1) != 0) begin
               c = ($urandom_range(0, 1) != 0) ? CHAR_PLUS : CHAR_MINUS;
            end else if (lead == CHAR_R && $urandom_range(0, 1) != 0) begin
               c = CHAR_0 + 8'($urandom_range(0, 9));
            end
            bytes_out.push_back(c);
         end
         pick = $urandom_range(0, 99);
         if (forced_params >= 0) nparam = forced_params;
         else if (pick < 80) nparam = $urandom_range(0, 6);
         else if (pick < 95) nparam = $urandom_range(7, 30);
         else nparam = $urandom_range(55, 70);
         for (int k = 0; k < nparam; k++) begin
            c = 8'($urandom_range(0, 255));
            while (c == tracker.term_char) c = 8'($urandom_range(0, 255));
            bytes_out.push_back(c);
         end
         bytes_out.push_back(tracker.term_char);
      end else begin
         nparam = $urandom_range(1, 12);
         for (int k = 0; k < nparam; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) c = tracker.term_char;
            else if (pick < 35) c = tracker.prefix_char;
            else c = 8'($urandom_range(0, 255));
            bytes_out.push_back(c);
         end
      end
      foreach (bytes_out[i]) send_byte(bytes_out[i]);
   endtask

   task automatic send_random_bytes(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) send_random_frame(-1);
   endtask

   // Drop valid and wait until every result has come back.
   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [7:0] value);
      logic [CSR_DATA_W-1:0] data;
      data        = $urandom;
      data[7:0]   = value;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Result side: random stalls, quiet stretches, and a long hold-off now and then.
   initial begin
      int stall;
      int quiet;
      int pick;
      int next_hold;
      stall         = 0;
      quiet         = 0;
      next_hold     = 150;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && results_seen >= next_hold) begin
            rsp_bus.ready = 1'b0;
            repeat (80) @(negedge clock);
            next_hold = results_seen + 400;
         end else if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else if (quiet > 0) begin
            rsp_bus.ready = 1'b1;
            quiet--;
         end else begin
            rsp_bus.ready = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 15) stall = $urandom_range(1, 3);
            else if (pick < 18) stall = $urandom_range(8, 25);
            else if (pick < 22) quiet = $urandom_range(30, 80);
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status       = rsp_bus.status;
         got.byte_role    = rsp_bus.byte_role;
         got.echo_byte    = rsp_bus.echo_byte;
         got.cmd_first    = rsp_bus.cmd_first;
         got.cmd_second   = rsp_bus.cmd_second;
         got.cmd_third    = rsp_bus.cmd_third;
         got.cmd_length   = rsp_bus.cmd_length;
         got.family       = rsp_bus.family;
         got.has_param    = rsp_bus.has_param;
         got.param_length = rsp_bus.param_length;
         tracker.check_result(got);
         results_seen++;
      end
   end

   initial begin
      // terminator first, letters, sign and digit tails, zero and all-ones bytes,
      // empty command, wrong first byte
      logic [7:0] opening [26] = '{
         "#",
         ":", "G", "R", "#",
         ":", "B", "+", "1", "#",
         ":", "R", "5", "A", "x", "#",
         ":", "g", 8'h00, 8'hFF, "#",
         ":", "#",
         "x", ":", "#"
      };
      logic [7:0] prefix_set [6] = '{8'h00, 8'hFF, "#", "A", ":", 8'h7F};
      logic [7:0] term_set   [6] = '{8'hFF, 8'h00, "G", "A", "#", 8'h80};
      int         limit;

      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (opening[i]) send_byte(opening[i]);
      send_random_frame(61);
      send_random_frame(70);
      send_random_bytes(180);

      foreach (prefix_set[p]) begin
         drain_results();
         csr_write(REG_PREFIX, prefix_set[p]);
         csr_write(REG_TERMINATOR, term_set[p]);
         send_random_bytes((prefix_set[p] == term_set[p]) ? 60 : 140);
      end

      req_bus.valid = 1'b0;
      limit = 0;
      while (tracker.pending() != 0 && limit < 5000) begin
         @(posedge clock);
         limit++;
      end
      repeat (5) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
